[design/svp_pkg.sv]
package svp_pkg;

    localparam int SECTOR_SPAN     = 10923;
    localparam int NUM_SECTORS     = 6;
    localparam int NSTAGE          = 7;

    localparam logic [15:0] PERIOD_RESET    = 16'd1499;
    localparam logic [14:0] MOD_INDEX_RESET = 15'd3000;
    localparam logic [14:0] MOD_INDEX_CAP   = 15'd28377;

    localparam int QSINE_DEPTH = 16385;
    localparam int QSINE_AW    = $clog2(QSINE_DEPTH);
    localparam int QSINE_QTR   = 16384;

    localparam logic [63:0] TWO_PI_Q60_HI = 64'h0000_6487_ED51_10B4;
    localparam logic [63:0] TWO_PI_Q60_LO = 64'h0000_0000_0000_611A;

    typedef enum logic [1:0] {
        REG_PERIOD    = 2'd0,
        REG_MOD_INDEX = 2'd1
    } cfg_reg_t;

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[123:60];
    endfunction

    function automatic logic [63:0] taylor_div(input logic [63:0] t, input int k);
        logic [63:0] res;
        case (k)
            1:       res = t / 64'd6;
            2:       res = t / 64'd20;
            3:       res = t / 64'd42;
            4:       res = t / 64'd72;
            5:       res = t / 64'd110;
            6:       res = t / 64'd156;
            7:       res = t / 64'd210;
            8:       res = t / 64'd272;
            9:       res = t / 64'd342;
            10:      res = t / 64'd420;
            11:      res = t / 64'd506;
            default: res = t / 64'd600;
        endcase
        return res;
    endfunction

    function automatic logic [14:0] quarter_sine(input logic [QSINE_AW-1:0] r);
        logic [63:0] rr;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] scaled;
        rr   = 64'(r);
        x    = rr * TWO_PI_Q60_HI + ((rr * TWO_PI_Q60_LO) >> 16);
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int k = 1; k <= 12; k++)
        begin
            term = taylor_div(mul_q60(term, x2), k);
            if ((k & 1) != 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        scaled = (((sum >> 20) * 64'd32767) + (64'd1 << 39)) >> 40;
        return scaled[14:0];
    endfunction

endpackage

[design/svp_sector.sv]
module svp_sector (
    input  logic                          clk,
    input  logic [1:0]                    en,
    input  logic [15:0]                   angle,
    output logic [2:0]                    sector,
    output logic [svp_pkg::QSINE_AW-1:0]  addr1,
    output logic                          neg1,
    output logic [svp_pkg::QSINE_AW-1:0]  addr2,
    output logic                          neg2
);
    import svp_pkg::*;

    localparam logic [16:0] SPAN17 = 17'(SECTOR_SPAN);

    logic [2:0]  sec_next;
    logic [15:0] offset;
    logic [15:0] th_next;
    logic [15:0] comp_next;
    logic [2:0]  sec1_reg;
    logic [15:0] th_reg;
    logic [15:0] comp_reg;
    logic [2:0]  sec2_reg;
    logic [QSINE_AW-1:0] addr1_reg;
    logic [QSINE_AW-1:0] addr2_reg;
    logic        neg1_reg;
    logic        neg2_reg;
    logic [QSINE_AW-1:0] addr1_next;
    logic [QSINE_AW-1:0] addr2_next;

    always_comb
    begin
        sec_next = 3'd0;
        offset   = 16'd0;
        for (int k = 1; k < NUM_SECTORS; k++)
        begin
            if ({1'b0, angle} >= 17'(SPAN17 * 17'(k)))
            begin
                sec_next = 3'(k);
                offset   = 16'(SPAN17 * 17'(k));
            end
        end
        th_next   = angle - offset;
        comp_next = SPAN17[15:0] - th_next;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sec1_reg <= sec_next;
            th_reg   <= th_next;
            comp_reg <= comp_next;
        end
    end

    always_comb
    begin
        addr1_next = comp_reg[14] ? QSINE_AW'(QSINE_QTR - int'(comp_reg[13:0]))
                                  : {1'b0, comp_reg[13:0]};
        addr2_next = th_reg[14]   ? QSINE_AW'(QSINE_QTR - int'(th_reg[13:0]))
                                  : {1'b0, th_reg[13:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sec2_reg  <= sec1_reg;
            addr1_reg <= addr1_next;
            addr2_reg <= addr2_next;
            neg1_reg  <= comp_reg[15];
            neg2_reg  <= th_reg[15];
        end
    end

    assign sector = sec2_reg;
    assign addr1  = addr1_reg;
    assign neg1   = neg1_reg;
    assign addr2  = addr2_reg;
    assign neg2   = neg2_reg;

endmodule

[design/svp_sine_rom.sv]
module svp_sine_rom (
    input  logic                          clk,
    input  logic                          en,
    input  logic [2:0]                    sector_in,
    input  logic [svp_pkg::QSINE_AW-1:0]  addr1,
    input  logic                          neg1_in,
    input  logic [svp_pkg::QSINE_AW-1:0]  addr2,
    input  logic                          neg2_in,
    output logic [2:0]                    sector,
    output logic [14:0]                   mag1,
    output logic                          neg1,
    output logic [14:0]                   mag2,
    output logic                          neg2
);
    import svp_pkg::*;

    logic [14:0] qsine_mem [QSINE_DEPTH];

    logic [2:0]  sec_reg;
    logic [14:0] mag1_reg;
    logic [14:0] mag2_reg;
    logic        neg1_reg;
    logic        neg2_reg;

    initial
    begin
        for (int i = 0; i < QSINE_DEPTH; i++)
        begin
            qsine_mem[i] = quarter_sine(QSINE_AW'(i));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg <= qsine_mem[addr1];
            mag2_reg <= qsine_mem[addr2];
            sec_reg  <= sector_in;
            neg1_reg <= neg1_in;
            neg2_reg <= neg2_in;
        end
    end

    assign sector = sec_reg;
    assign mag1   = mag1_reg;
    assign neg1   = neg1_reg;
    assign mag2   = mag2_reg;
    assign neg2   = neg2_reg;

endmodule

[design/svp_vector_time.sv]
module svp_vector_time (
    input  logic        clk,
    input  logic [1:0]  en,
    input  logic [15:0] period,
    input  logic [14:0] mod_index,
    input  logic [2:0]  sector_in,
    input  logic [14:0] mag1,
    input  logic        neg1,
    input  logic [14:0] mag2,
    input  logic        neg2,
    output logic [2:0]  sector,
    output logic [15:0] t1,
    output logic [15:0] t2
);
    import svp_pkg::*;

    logic signed [15:0] s1;
    logic signed [15:0] s2;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic signed [15:0] q1_reg;
    logic signed [15:0] q2_reg;
    logic [2:0]         sec4_reg;
    logic signed [32:0] pt1;
    logic signed [32:0] pt2;
    logic signed [32:0] adj1;
    logic signed [32:0] adj2;
    logic [15:0]        t1_reg;
    logic [15:0]        t2_reg;
    logic [2:0]         sec5_reg;

    always_comb
    begin
        s1 = neg1 ? 16'sd0 - signed'({1'b0, mag1}) : signed'({1'b0, mag1});
        s2 = neg2 ? 16'sd0 - signed'({1'b0, mag2}) : signed'({1'b0, mag2});
        p1 = s1 * signed'({1'b0, mod_index});
        p2 = s2 * signed'({1'b0, mod_index});
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            q1_reg   <= p1[30:15];
            q2_reg   <= p2[30:15];
            sec4_reg <= sector_in;
        end
    end

    // truncate toward zero: bias negatives before the shift
    always_comb
    begin
        pt1  = q1_reg * signed'({1'b0, period});
        pt2  = q2_reg * signed'({1'b0, period});
        adj1 = pt1[32] ? pt1 + 33'sd32767 : pt1;
        adj2 = pt2[32] ? pt2 + 33'sd32767 : pt2;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            t1_reg   <= adj1[30:15];
            t2_reg   <= adj2[30:15];
            sec5_reg <= sec4_reg;
        end
    end

    assign sector = sec5_reg;
    assign t1     = t1_reg;
    assign t2     = t2_reg;

endmodule

[design/svp_interval.sv]
module svp_interval (
    input  logic        clk,
    input  logic [1:0]  en,
    input  logic [15:0] period,
    input  logic [2:0]  sector_in,
    input  logic [15:0] t1,
    input  logic [15:0] t2,
    output logic [2:0]  sector,
    output logic [15:0] phase_u_compare,
    output logic [15:0] phase_v_compare,
    output logic [15:0] phase_w_compare
);
    import svp_pkg::*;

    logic [15:0] zero;
    logic [15:0] first_reg;
    logic [15:0] tsel_reg;
    logic [2:0]  sec6_reg;
    logic [15:0] second;
    logic [15:0] third;
    logic [15:0] u_next;
    logic [15:0] v_next;
    logic [15:0] w_next;
    logic [15:0] u_reg;
    logic [15:0] v_reg;
    logic [15:0] w_reg;
    logic [2:0]  sec7_reg;

    assign zero = period - t1 - t2;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            first_reg <= {1'b0, zero[15:1]};
            tsel_reg  <= sector_in[0] ? t1 : t2;
            sec6_reg  <= sector_in;
        end
    end

    always_comb
    begin
        second = period - first_reg - tsel_reg;
        third  = period - first_reg;
        case (sec6_reg)
            3'd0:
            begin
                u_next = first_reg; v_next = second;    w_next = third;
            end
            3'd1:
            begin
                u_next = second;    v_next = first_reg; w_next = third;
            end
            3'd2:
            begin
                u_next = third;     v_next = first_reg; w_next = second;
            end
            3'd3:
            begin
                u_next = third;     v_next = second;    w_next = first_reg;
            end
            3'd4:
            begin
                u_next = second;    v_next = third;     w_next = first_reg;
            end
            default:
            begin
                u_next = first_reg; v_next = third;     w_next = second;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            u_reg    <= u_next;
            v_reg    <= v_next;
            w_reg    <= w_next;
            sec7_reg <= sec6_reg;
        end
    end

    assign sector          = sec7_reg;
    assign phase_u_compare = u_reg;
    assign phase_v_compare = v_reg;
    assign phase_w_compare = w_reg;

endmodule

[design/svpwm_phase_compare_core.sv]
// Space vector PWM compare generator.
// Input stream s_axis: one electrical angle per word (65536 = one turn).
// Output stream m_axis: one word per angle with the sector and the timer
// compare counts for phases U, V and W, in input order.
// Config channel cfg_*: index 0 writes the timer period, index 1 the Q15
// modulation index (values above 28377 saturate). cfg_ready is always high;
// write only while no angle is in flight.
// Pipeline: the result word shows on m_axis once its angle has passed the
// seven register stages (sector split, ROM address, sine ROM read,
// modulation multiply, period multiply, zero time, phase steering).
// Throughput: one angle per cycle while m_axis is not stalled. Each stage
// moves on when it is empty or the stage after it moves, so a stalled
// m_axis fills empty stages before s_axis_tready drops; no word is lost
// or repeated.
// Reset: all stages empty, period 1499, modulation index 3000.
module svpwm_phase_compare_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [15:0] electrical_angle
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // [2:0] sector, [18:3] phase_u_compare,
                                       // [34:19] phase_v_compare,
                                       // [50:35] phase_w_compare, [55:51] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import svp_pkg::*;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] en;
    logic [15:0]       period_reg;
    logic [14:0]       mod_index_reg;
    logic [14:0]       mod_cfg;

    logic [2:0]          sec_a;
    logic [QSINE_AW-1:0] addr1;
    logic [QSINE_AW-1:0] addr2;
    logic                neg1_a;
    logic                neg2_a;
    logic [2:0]          sec_b;
    logic [14:0]         mag1;
    logic [14:0]         mag2;
    logic                neg1_b;
    logic                neg2_b;
    logic [2:0]          sec_c;
    logic [15:0]         t1;
    logic [15:0]         t2;
    logic [2:0]          sec_out;
    logic [15:0]         u_out;
    logic [15:0]         v_out;
    logic [15:0]         w_out;

    always_comb
    begin
        en[NSTAGE-1] = ~valid_reg[NSTAGE-1] | m_axis_tready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            en[k] = ~valid_reg[k] | en[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
            valid_next[0] = s_axis_tvalid;
        for (int k = 1; k < NSTAGE; k++)
        begin
            if (en[k])
                valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // saturate the modulation index at its cap
    assign mod_cfg   = (cfg_data[14:0] > MOD_INDEX_CAP) ? MOD_INDEX_CAP : cfg_data[14:0];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RESET;
            mod_index_reg <= MOD_INDEX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PERIOD:    period_reg    <= cfg_data;
                REG_MOD_INDEX: mod_index_reg <= mod_cfg;
                default:       ;
            endcase
        end
    end

    svp_sector u_sector (
        .clk    (clk),
        .en     (en[1:0]),
        .angle  (s_axis_tdata),
        .sector (sec_a),
        .addr1  (addr1),
        .neg1   (neg1_a),
        .addr2  (addr2),
        .neg2   (neg2_a)
    );

    svp_sine_rom u_rom (
        .clk       (clk),
        .en        (en[2]),
        .sector_in (sec_a),
        .addr1     (addr1),
        .neg1_in   (neg1_a),
        .addr2     (addr2),
        .neg2_in   (neg2_a),
        .sector    (sec_b),
        .mag1      (mag1),
        .neg1      (neg1_b),
        .mag2      (mag2),
        .neg2      (neg2_b)
    );

    svp_vector_time u_vtime (
        .clk       (clk),
        .en        (en[4:3]),
        .period    (period_reg),
        .mod_index (mod_index_reg),
        .sector_in (sec_b),
        .mag1      (mag1),
        .neg1      (neg1_b),
        .mag2      (mag2),
        .neg2      (neg2_b),
        .sector    (sec_c),
        .t1        (t1),
        .t2        (t2)
    );

    svp_interval u_interval (
        .clk             (clk),
        .en              (en[6:5]),
        .period          (period_reg),
        .sector_in       (sec_c),
        .t1              (t1),
        .t2              (t2),
        .sector          (sec_out),
        .phase_u_compare (u_out),
        .phase_v_compare (v_out),
        .phase_w_compare (w_out)
    );

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = valid_reg[NSTAGE-1];
    assign m_axis_tdata  = {5'd0, w_out, v_out, u_out, sec_out};

endmodule

[design/svp_checker.sv]
module svp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import svp_pkg::*;

    logic [15:0] period_reg;
    logic [15:0] pair_sum;
    logic [15:0] u_val;
    logic [15:0] v_val;
    logic [15:0] w_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= PERIOD_RESET;
        else if (cfg_valid && cfg_ready && cfg_index == REG_PERIOD)
            period_reg <= cfg_data;
    end

    assign u_val = m_axis_tdata[18:3];
    assign v_val = m_axis_tdata[34:19];
    assign w_val = m_axis_tdata[50:35];

    // first and third intervals always add up to the period
    always_comb
    begin
        case (m_axis_tdata[2:0])
            3'd0:    pair_sum = u_val + w_val;
            3'd1:    pair_sum = v_val + w_val;
            3'd2:    pair_sum = v_val + u_val;
            3'd3:    pair_sum = w_val + u_val;
            3'd4:    pair_sum = w_val + v_val;
            default: pair_sum = u_val + v_val;
        endcase
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd5 && m_axis_tdata[55:51] == 5'd0)
        else $error("sector out of range");

    a_pair_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pair_sum == period_reg)
        else $error("first and third intervals do not sum to the period");

    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is free");

endmodule

bind svpwm_phase_compare_core svp_checker u_svp_checker (.*);
